// ===== rtl/core/lifet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifet_pkg: shared types and constants of the life torus unit
// Request, response and configuration payloads, operation and register codes,
// sequencer states and the B3/S23 rule counts.
// ----------------------------------------------------------------------------
package lifet_pkg;

  // default grid capacity
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // payload field widths
  localparam int COLUMN_W    = 6;
  localparam int ROW_W       = 6;
  localparam int GRID_W      = 7;
  localparam int CFG_INDEX_W = 2;

  // grid size after reset
  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

  // neighbour counts of the rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // request operations
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    kind_t               kind;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                cell_in;
  } req_t;

  typedef struct packed {
    logic cell_out;
    logic unchanged;
    logic out_of_range;
  } rsp_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [GRID_W-1:0]      value;
  } cfg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_CELL,
    ST_STORE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/lifet_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifet_if: channel interfaces of the life torus unit
// Valid/ready channels for requests, responses and configuration writes.
// ----------------------------------------------------------------------------
interface lifet_req_if;
  import lifet_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lifet_rsp_if;
  import lifet_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lifet_cfg_if;
  import lifet_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lifet_rule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifet_rule: shared neighbour count and B3/S23 rule
// Counts the eight neighbour bits of one cell and gives its next state.
// ----------------------------------------------------------------------------
module lifet_rule (
  input  logic [7:0] nbr,
  input  logic       alive,
  output logic       alive_next
);
  import lifet_pkg::*;

  logic [3:0] count;

  // population count of the neighbourhood
  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + {3'b000, nbr[i]};
    end
  end

  // born on three, kept on two
  assign alive_next = (count == BIRTH_COUNT) || ((count == KEEP_COUNT) && alive);

endmodule

// ===== rtl/core/life_cellular_automaton_torus_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_torus_unit: Game of Life engine on a wrapped grid
// Cell write, cell read and one-generation step over a row-wide cell memory.
// ----------------------------------------------------------------------------
// After reset the unit clears its cell memory one row per cycle before the
// first request is taken; configuration writes are taken at any time. A cell
// write or read in range reads the row from memory, writes it back updated on
// a write, and then returns its response from the response register; an access
// outside the grid or an unused operation goes straight to its response. A
// generation step walks the grid row by row: per row it loads the rows above,
// at and below into registers, runs the single neighbour/rule unit once per
// column, and stores the new row in a scratch memory; a copy pass then moves
// the H rows back, each by a scratch read and a cell write. The rule unit
// handles one cell per cycle. The unit takes one request at a time and
// accepts the next while a response waits.
// ----------------------------------------------------------------------------
module life_cellular_automaton_torus_unit #(
  parameter int MAX_COLUMNS = lifet_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lifet_pkg::DEF_MAX_ROWS
) (
  input  logic            clk,
  input  logic            rst,
  lifet_req_if.sink       req,
  lifet_rsp_if.source     rsp,
  lifet_cfg_if.sink       cfg
);
  import lifet_pkg::*;

  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int YW = $clog2(MAX_ROWS);
  localparam int UW = $clog2(MAX_COLUMNS + 1);
  localparam int UH = $clog2(MAX_ROWS + 1);

  state_t state, state_next;

  logic [GRID_W-1:0] grid_width, grid_height;
  logic [UW-1:0]     used_w, sw;
  logic [UH-1:0]     used_h, sh;

  logic [XW-1:0] x, xm, xp, acc_x;
  logic [YW-1:0] y, acc_y;
  logic [1:0]    ld;
  kind_t         acc_kind;
  logic          acc_val;
  rsp_t          res;
  logic          oor;
  logic          x_last, y_last;

  logic [MAX_COLUMNS-1:0] row_up, row_cur, row_dn, row_nxt;

  // cell memories, one row per entry
  logic [MAX_COLUMNS-1:0] cells_mem [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] next_mem  [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] cells_rd, next_rd, cells_wdata;
  logic                   cells_re, cells_we, next_re, next_we;
  logic [YW-1:0]          cells_raddr, cells_waddr;

  logic [7:0] nbr;
  logic       alive_next;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_GRID_WIDTH:  grid_width  <= cfg.data.value;
        CFG_GRID_HEIGHT: grid_height <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // grid size in use, zero acts as one, large values saturate
  always_comb begin
    if (grid_width == '0) begin
      used_w = UW'(1);
    end else if (32'(grid_width) > MAX_COLUMNS) begin
      used_w = UW'(MAX_COLUMNS);
    end else begin
      used_w = UW'(grid_width);
    end
    if (grid_height == '0) begin
      used_h = UH'(1);
    end else if (32'(grid_height) > MAX_ROWS) begin
      used_h = UH'(MAX_ROWS);
    end else begin
      used_h = UH'(grid_height);
    end
  end

  assign oor = (32'(req.data.column) >= 32'(used_w)) || (32'(req.data.row) >= 32'(used_h));

  // wrapped column neighbours of the current cell
  assign x_last = (x == XW'(sw - UW'(1)));
  assign y_last = (y == YW'(sh - UH'(1)));
  assign xm     = (x == '0) ? XW'(sw - UW'(1)) : x - XW'(1);
  assign xp     = x_last ? '0 : x + XW'(1);

  assign nbr = {row_up[xm], row_up[x], row_up[xp],
                row_cur[xm], row_cur[xp],
                row_dn[xm], row_dn[x], row_dn[xp]};

  lifet_rule u_rule (
    .nbr        (nbr),
    .alive      (row_cur[x]),
    .alive_next (alive_next)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    cells_re    = 1'b0;
    cells_raddr = y;
    cells_we    = 1'b0;
    cells_waddr = y;
    cells_wdata = '0;
    next_re     = 1'b0;
    next_we     = 1'b0;
    case (state)
      ST_CLEAR: begin
        cells_we = 1'b1;
        if (y == YW'(MAX_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.data.kind == KIND_STEP) begin
            state_next = ST_LOAD;
          end else if ((req.data.kind inside {KIND_WRITE, KIND_READ}) && !oor) begin
            cells_re    = 1'b1;
            cells_raddr = YW'(req.data.row);
            state_next  = ST_ACC;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ACC: begin
        if (acc_kind == KIND_WRITE) begin
          cells_we           = 1'b1;
          cells_waddr        = acc_y;
          cells_wdata        = cells_rd;
          cells_wdata[acc_x] = acc_val;
        end
        state_next = ST_DONE;
      end
      ST_LOAD: begin
        case (ld)
          2'd0: begin
            cells_re    = 1'b1;
            cells_raddr = (y == '0) ? YW'(sh - UH'(1)) : y - YW'(1);
          end
          2'd1: begin
            cells_re = 1'b1;
          end
          2'd2: begin
            cells_re    = 1'b1;
            cells_raddr = y_last ? '0 : y + YW'(1);
          end
          default: begin
            state_next = ST_CELL;
          end
        endcase
      end
      ST_CELL: begin
        if (x_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        next_we    = 1'b1;
        state_next = y_last ? ST_COPY_RD : ST_LOAD;
      end
      ST_COPY_RD: begin
        next_re    = 1'b1;
        state_next = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cells_we    = 1'b1;
        cells_wdata = next_rd;
        state_next  = y_last ? ST_DONE : ST_COPY_RD;
      end
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // cell memory ports
  always_ff @(posedge clk) begin
    if (cells_we) begin
      cells_mem[cells_waddr] <= cells_wdata;
    end
    if (cells_re) begin
      cells_rd <= cells_mem[cells_raddr];
    end
  end

  // scratch memory ports
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[y] <= row_nxt;
    end
    if (next_re) begin
      next_rd <= next_mem[y];
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      y  <= '0;
      x  <= '0;
      ld <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          y <= y + YW'(1);
        end
        ST_IDLE: begin
          y  <= '0;
          ld <= '0;
        end
        ST_LOAD: begin
          ld <= ld + 2'd1;
          x  <= '0;
        end
        ST_CELL: begin
          x <= x + XW'(1);
        end
        ST_STORE: begin
          ld <= '0;
          y  <= y_last ? '0 : y + YW'(1);
        end
        ST_COPY_WR: begin
          y <= y + YW'(1);
        end
        default: ;
      endcase
    end
  end

  // request capture, row registers and result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          acc_kind <= req.data.kind;
          acc_x    <= XW'(req.data.column);
          acc_y    <= YW'(req.data.row);
          acc_val  <= req.data.cell_in;
          sw       <= used_w;
          sh       <= used_h;
          res      <= '{cell_out: 1'b0,
                        unchanged: (req.data.kind == KIND_STEP),
                        out_of_range: (req.data.kind inside {KIND_WRITE, KIND_READ}) && oor};
        end
      end
      ST_ACC: begin
        if (acc_kind == KIND_READ) begin
          res.cell_out <= cells_rd[acc_x];
        end
      end
      ST_LOAD: begin
        case (ld)
          2'd1: row_up <= cells_rd;
          2'd2: row_cur <= cells_rd;
          2'd3: begin
            row_dn  <= cells_rd;
            row_nxt <= row_cur;
          end
          default: ;
        endcase
      end
      ST_CELL: begin
        row_nxt[x] <= alive_next;
        if (alive_next != row_cur[x]) begin
          res.unchanged <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.data <= res;
    end
  end

  // column sweep stays inside the grid snapshot
  a_col_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CELL) |-> (UW'(x) < sw))
    else $error("column sweep ran past the grid width");

  // row store stays inside the grid snapshot
  a_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |-> (UH'(y) < sh))
    else $error("row store ran past the grid height");

  // a response is raised only on completion
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == ST_DONE))
    else $error("response raised outside completion");

  // a waiting response is never overwritten
  a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && rsp.valid && !rsp.ready) |=> (state == ST_DONE))
    else $error("completion left while response stalled");

endmodule

// ===== verif/life_grid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_checker: response checker of the life torus unit
// Watches the request, response and configuration channels, keeps its own
// copy of the cell grid and grid size, works out the response each accepted
// request must get and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module life_grid_checker #(
  parameter int MAX_COLUMNS = lifet_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lifet_pkg::DEF_MAX_ROWS
) (
  input  logic  clk,
  input  logic  rst,
  lifet_req_if  req,
  lifet_rsp_if  rsp,
  lifet_cfg_if  cfg,
  output int    failures,
  output int    outstanding
);
  import lifet_pkg::*;

  // mirrored grid state and size registers
  bit                board   [MAX_COLUMNS*MAX_ROWS];
  bit                scratch [MAX_COLUMNS*MAX_ROWS];
  logic [GRID_W-1:0] width_reg;
  logic [GRID_W-1:0] height_reg;
  rsp_t              pending_responses[$];

  // size in use: zero acts as one, large values saturate
  function automatic int span_of(logic [GRID_W-1:0] v, int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  // one B3/S23 generation over the grid in use, returns 1 if nothing changed
  function automatic bit next_generation();
    int w;
    int h;
    int n;
    int nx;
    int ny;
    int at;
    bit same;
    w = span_of(width_reg, MAX_COLUMNS);
    h = span_of(height_reg, MAX_ROWS);
    same = 1'b1;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        n = 0;
        // every neighbour position counted on its own, even when wraps fold
        for (int dy = 0; dy < 3; dy++) begin
          for (int dx = 0; dx < 3; dx++) begin
            if (dx != 1 || dy != 1) begin
              nx = (x + w + dx - 1) % w;
              ny = (y + h + dy - 1) % h;
              n += board[ny*MAX_COLUMNS + nx];
            end
          end
        end
        at = y*MAX_COLUMNS + x;
        if (n == int'(BIRTH_COUNT)) scratch[at] = 1'b1;
        else if (n == int'(KEEP_COUNT)) scratch[at] = board[at];
        else scratch[at] = 1'b0;
      end
    end
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        at = y*MAX_COLUMNS + x;
        if (board[at] != scratch[at]) same = 1'b0;
        board[at] = scratch[at];
      end
    end
    return same;
  endfunction

  // response to one request, applied to the mirrored grid
  function automatic rsp_t life_response(req_t r);
    rsp_t e;
    int   at;
    e  = '0;
    at = int'(r.row)*MAX_COLUMNS + int'(r.column);
    case (r.kind)
      KIND_STEP: begin
        e.unchanged = next_generation();
      end
      KIND_WRITE, KIND_READ: begin
        if (int'(r.column) >= span_of(width_reg, MAX_COLUMNS) ||
            int'(r.row) >= span_of(height_reg, MAX_ROWS)) begin
          e.out_of_range = 1'b1;
        end else if (r.kind == KIND_WRITE) begin
          board[at] = r.cell_in;
        end else begin
          e.cell_out = board[at];
        end
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  // track configuration, predict on request, compare on response
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      foreach (board[i]) board[i] = 1'b0;
      width_reg  = GRID_RESET;
      height_reg = GRID_RESET;
      pending_responses.delete();
      failures = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          CFG_GRID_WIDTH:  width_reg  = cfg.data.value;
          CFG_GRID_HEIGHT: height_reg = cfg.data.value;
          default: begin
          end
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (pending_responses.size() == 0) begin
          $error("response with no request outstanding");
          failures++;
        end else begin
          want = pending_responses.pop_front();
          if (want.cell_out !== got.cell_out) begin
            $error("cell_out mismatch: expected %0d, got %0d", want.cell_out, got.cell_out);
            failures++;
          end
          if (want.unchanged !== got.unchanged) begin
            $error("unchanged mismatch: expected %0d, got %0d",
                   want.unchanged, got.unchanged);
            failures++;
          end
          if (want.out_of_range !== got.out_of_range) begin
            $error("out_of_range mismatch: expected %0d, got %0d",
                   want.out_of_range, got.out_of_range);
            failures++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_responses.push_back(life_response(req.data));
      end
    end
    outstanding = pending_responses.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the life torus unit
// Drives directed corner cases, then random phases of seeded soups, steps,
// reads and stray accesses over many grid sizes, with random gaps and stalls
// on both sides; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import lifet_pkg::*;

  localparam kind_t                  KIND_UNUSED    = kind_t'(2'd3);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE      = 2'd3;
  localparam int                     WATCHDOG_LIMIT = 20000;
  localparam int                     LONG_HOLD      = 300;
  localparam int                     ITEM_TARGET    = 900;
  localparam int                     FULL_SIZE      = DEF_MAX_COLUMNS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   outstanding;
  int   quiet_cycles = 0;
  int   items_done = 0;
  int   cols = FULL_SIZE;
  int   rows = FULL_SIZE;
  bit   gaps_on = 1'b1;
  bit   stalls_on = 1'b1;
  bit   long_hold = 1'b0;

  lifet_req_if req_if ();
  lifet_rsp_if rsp_if ();
  lifet_cfg_if cfg_if ();

  always #4 clk = ~clk;

  life_cellular_automaton_torus_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  life_grid_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_if),
    .rsp         (rsp_if),
    .cfg         (cfg_if),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // size in use, for shaping coordinates
  function automatic int grid_span(logic [GRID_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > FULL_SIZE) return FULL_SIZE;
    return int'(v);
  endfunction

  // one request, after a random gap
  task automatic send(input kind_t k, input int col, input int row, input bit val);
    req_t r;
    int   gap;
    r.kind    = k;
    r.column  = col[COLUMN_W-1:0];
    r.row     = row[ROW_W-1:0];
    r.cell_in = val;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (k == KIND_STEP || ((k == KIND_WRITE || k == KIND_READ) && col < cols && row < rows))
      items_done++;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.data  <= r;
    req_if.valid <= 1'b1;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  // stop offering and wait until every response is back
  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one configuration register write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [GRID_W-1:0] v);
    cfg_t c;
    c.index = idx;
    c.value = v;
    @(negedge clk);
    cfg_if.data  <= c;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // resize the grid while idle
  task automatic set_grid(input logic [GRID_W-1:0] w, input logic [GRID_W-1:0] h);
    settle();
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    cols = grid_span(w);
    rows = grid_span(h);
  endtask

  // corner cases at full size, degenerate sizes and saturated sizes
  task automatic directed_checks();
    send(KIND_READ, 0, 0, 1'b0);
    send(KIND_WRITE, 63, 63, 1'b1);
    send(KIND_READ, 63, 63, 1'b0);
    send(KIND_STEP, 0, 0, 1'b0);
    send(KIND_STEP, 63, 63, 1'b1);
    send(KIND_UNUSED, 63, 63, 1'b1);
    // block still life straddling both wraps
    send(KIND_WRITE, 63, 63, 1'b1);
    send(KIND_WRITE, 0, 63, 1'b1);
    send(KIND_WRITE, 63, 0, 1'b1);
    send(KIND_WRITE, 0, 0, 1'b1);
    send(KIND_STEP, 0, 0, 1'b0);
    send(KIND_READ, 0, 0, 1'b0);
    // zero width acts as one, two rows fold onto the same cells
    set_grid(7'd0, 7'd2);
    send(KIND_WRITE, 0, 1, 1'b1);
    send(KIND_WRITE, 1, 0, 1'b1);
    send(KIND_READ, 0, 2, 1'b0);
    send(KIND_STEP, 0, 0, 1'b0);
    send(KIND_READ, 0, 0, 1'b0);
    // oversize width saturates, single row
    set_grid(7'd127, 7'd1);
    send(KIND_READ, 1, 0, 1'b0);
    send(KIND_WRITE, 10, 0, 1'b1);
    send(KIND_WRITE, 11, 0, 1'b1);
    send(KIND_WRITE, 12, 0, 1'b1);
    send(KIND_STEP, 0, 0, 1'b0);
    send(KIND_STEP, 0, 0, 1'b0);
    // index beyond the register list is ignored
    settle();
    write_reg(CFG_SPARE, 7'd5);
    send(KIND_READ, 11, 0, 1'b0);
  endtask

  // random soup on a random grid, then steps with reads and stray accesses
  task automatic run_phase(input bit go_large);
    int w;
    int h;
    int n;
    int steps;
    int c;
    int r;
    if (go_large) begin
      w = $urandom_range(40, 127);
      h = $urandom_range(40, 127);
    end else if ($urandom_range(0, 7) == 0) begin
      w = $urandom_range(0, 2);
      h = $urandom_range(0, 4);
    end else begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 12);
    end
    set_grid(w[GRID_W-1:0], h[GRID_W-1:0]);
    gaps_on   = $urandom_range(0, 2) != 0;
    stalls_on = $urandom_range(0, 2) != 0;

    // seed the soup, mostly live cells
    n = cols*rows/2 + 2;
    if (n > 24) n = 24;
    n = $urandom_range(2, n);
    repeat (n)
      send(KIND_WRITE, $urandom_range(0, cols-1), $urandom_range(0, rows-1),
           $urandom_range(0, 3) != 0);
    // sometimes a block at a random spot, wrapping if need be
    if ($urandom_range(0, 2) == 0) begin
      c = $urandom_range(0, cols-1);
      r = $urandom_range(0, rows-1);
      send(KIND_WRITE, c, r, 1'b1);
      send(KIND_WRITE, (c+1) % cols, r, 1'b1);
      send(KIND_WRITE, c, (r+1) % rows, 1'b1);
      send(KIND_WRITE, (c+1) % cols, (r+1) % rows, 1'b1);
    end

    steps = go_large ? $urandom_range(1, 2) : $urandom_range(2, 8);
    repeat (steps) begin
      send(KIND_STEP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      repeat ($urandom_range(1, 4))
        send(KIND_READ, $urandom_range(0, cols-1), $urandom_range(0, rows-1),
             $urandom_range(0, 1));
      // stray access: unused kind or outside the grid
      if ($urandom_range(0, 3) == 0) begin
        c = $urandom_range(0, 63);
        r = $urandom_range(0, 63);
        if (cols < FULL_SIZE && $urandom_range(0, 1) == 1) c = $urandom_range(cols, 63);
        else if (rows < FULL_SIZE) r = $urandom_range(rows, 63);
        if ($urandom_range(0, 2) == 0 || (c < cols && r < rows))
          send(KIND_UNUSED, c, r, $urandom_range(0, 1));
        else
          send($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, c, r, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 4) == 0)
        send(KIND_WRITE, $urandom_range(0, cols-1), $urandom_range(0, rows-1),
             $urandom_range(0, 1));
    end

    // full read-back of small grids
    if (cols*rows <= 16 && $urandom_range(0, 2) == 0) begin
      for (r = 0; r < rows; r++)
        for (c = 0; c < cols; c++)
          send(KIND_READ, c, r, 1'b0);
    end
  endtask

  // response side: random stalls, one long hold-off on request
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = stalls_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int phase;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();

    phase = 0;
    while (items_done < ITEM_TARGET) begin
      run_phase(phase % 12 == 5);
      // fill the unit while responses are held back, then drain
      if (phase == 1) begin
        settle();
        gaps_on   = 1'b0;
        long_hold = 1'b1;
        repeat (12)
          send(KIND_READ, $urandom_range(0, cols-1), $urandom_range(0, rows-1), 1'b0);
        settle();
      end
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
